@@ rtl/jsd_pkg.sv @@
// ---------------------------------------------------------------------------
// jsd_pkg: shared types and constants for job sequencing with deadlines
// Sizes of the job store and the slot table, request and entry types, and
// the scheduler state encoding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsd_pkg;

  localparam int MaxJobs  = 64;
  localparam int MaxSlots = 64;
  localparam int JobIdxW  = $clog2(MaxJobs);
  localparam int JobCntW  = $clog2(MaxJobs + 1);
  localparam int SlotIdxW = $clog2(MaxSlots);
  localparam int SlotCntW = $clog2(MaxSlots + 1);
  localparam int IdW      = 8;
  localparam int DlW      = 7;
  localparam int ProfitW  = 16;
  localparam int SumW     = 22;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // one job request as it travels through the queue
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [DlW-1:0]     deadline;
    logic [ProfitW-1:0] profit;
    logic               last;
  } job_t;

  // one job store entry
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [DlW-1:0]     deadline;
    logic [ProfitW-1:0] profit;
  } store_t;

  // one slot table entry
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [ProfitW-1:0] profit;
  } slot_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SEARCH,
    ST_EMIT,
    ST_FINISH
  } sched_state_e;

endpackage

@@ rtl/jsd_fifo.sv @@
// ---------------------------------------------------------------------------
// jsd_fifo: short job request queue
// Decouples the accepting front end from the scheduling back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jsd_pkg::job_t        push_data_i,
  input  logic                 pop_i,
  output jsd_pkg::job_t        head_o,
  output jsd_pkg::q_status_t   status_o
);

  jsd_pkg::job_t                  mem_q [jsd_pkg::QDepth];
  logic [jsd_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [jsd_pkg::QCntW-1:0]      cnt_q;
  logic                           do_push, do_pop;

  assign status_o.full  = (cnt_q == jsd_pkg::QCntW'(jsd_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/jsd_front.sv @@
// ---------------------------------------------------------------------------
// jsd_front: request intake
// Takes jobs, saturates deadlines, and closes the set after the last job
// until the back end reports the schedule has been emitted.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [jsd_pkg::IdW-1:0]       job_id_i,
  input  logic [jsd_pkg::DlW-1:0]       job_deadline_i,
  input  logic [jsd_pkg::ProfitW-1:0]   job_profit_i,
  input  logic                          last_job_i,
  input  jsd_pkg::q_status_t            q_status_i,
  input  logic                          set_done_i,
  output logic                          busy_o,
  output logic                          push_o,
  output jsd_pkg::job_t                 push_data_o
);

  logic closed_q;

  assign busy_o = q_status_i.full || closed_q;
  assign push_o = start_i && !busy_o;

  // deadline saturation at the slot count
  always_comb begin
    push_data_o.id       = job_id_i;
    push_data_o.profit   = job_profit_i;
    push_data_o.last     = last_job_i;
    push_data_o.deadline = (job_deadline_i > jsd_pkg::DlW'(jsd_pkg::MaxSlots))
                           ? jsd_pkg::DlW'(jsd_pkg::MaxSlots) : job_deadline_i;
  end

  // set closed from last job until emission is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
    end else if (push_o && last_job_i) begin
      closed_q <= 1'b1;
    end else if (set_done_i) begin
      closed_q <= 1'b0;
    end
  end

endmodule

@@ rtl/jsd_back.sv @@
// ---------------------------------------------------------------------------
// jsd_back: scheduler
// Stores jobs, repeatedly picks the most profitable unplaced job (first
// arrival wins ties), walks down from its deadline to the latest free slot,
// then reads out the slot table in time order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  jsd_pkg::job_t                  head_i,
  input  logic                           q_empty_i,
  output logic                           pop_o,
  output logic                           set_done_o,
  output logic                           slot_valid_o,
  output logic [jsd_pkg::SlotIdxW-1:0]   slot_index_o,
  output logic [jsd_pkg::IdW-1:0]        slot_job_id_o,
  output logic                           slot_filled_o,
  output logic [jsd_pkg::SumW-1:0]       running_profit_o,
  output logic                           last_slot_o
);

  jsd_pkg::sched_state_e state_q, state_d;

  // storage
  jsd_pkg::store_t                  store_mem [jsd_pkg::MaxJobs];
  jsd_pkg::slot_t                   slot_mem  [jsd_pkg::MaxSlots];
  jsd_pkg::store_t                  store_rd_q;
  jsd_pkg::slot_t                   slot_rd_q;

  logic [jsd_pkg::JobCntW-1:0]      count_q;
  logic [jsd_pkg::SlotCntW-1:0]     gd_q;
  logic [jsd_pkg::SlotCntW-1:0]     filled_q;
  logic [jsd_pkg::MaxSlots-1:0]     used_q;
  logic [jsd_pkg::MaxJobs-1:0]      taken_q;

  // scan of the store
  logic [jsd_pkg::JobCntW-1:0]      addr_q;
  logic                             pv_q;
  logic [jsd_pkg::JobIdxW-1:0]      pidx_q;
  logic                             best_v_q;
  logic [jsd_pkg::JobIdxW-1:0]      best_idx_q;
  jsd_pkg::store_t                  best_q;

  // slot search
  logic [jsd_pkg::DlW-1:0]          k_q;
  logic [jsd_pkg::DlW-1:0]          k_dec;
  logic [jsd_pkg::SlotIdxW-1:0]     kk;

  // read-out
  logic [jsd_pkg::SlotCntW-1:0]     e_q;
  logic                             ev_q, efill_q, elast_q;
  logic [jsd_pkg::SlotIdxW-1:0]     eidx_q;
  logic [jsd_pkg::SumW-1:0]         acc_q, acc_sum;

  // controls
  logic pop, scan_issue, scan_end, sched_full, slot_free, search_end;
  logic emit_issue, emit_end;

  assign k_dec = k_q - 1'b1;
  assign kk    = k_dec[jsd_pkg::SlotIdxW-1:0];

  // control outputs of the sequencer
  always_comb begin
    pop        = (state_q == jsd_pkg::ST_LOAD) && !q_empty_i;
    sched_full = (filled_q >= gd_q);
    scan_issue = (state_q == jsd_pkg::ST_SCAN) && !sched_full && (addr_q < count_q);
    scan_end   = (state_q == jsd_pkg::ST_SCAN) && !sched_full &&
                 (addr_q == count_q) && !pv_q;
    slot_free  = (state_q == jsd_pkg::ST_SEARCH) && (k_q != '0) && !used_q[kk];
    search_end = (state_q == jsd_pkg::ST_SEARCH) && ((k_q == '0) || !used_q[kk]);
    emit_issue = (state_q == jsd_pkg::ST_EMIT) && (e_q < gd_q);
    emit_end   = (state_q == jsd_pkg::ST_EMIT) && (e_q == gd_q);
    set_done_o = (state_q == jsd_pkg::ST_FINISH);
  end

  assign pop_o = pop;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jsd_pkg::ST_LOAD: begin
        if (pop && head_i.last) state_d = jsd_pkg::ST_SCAN;
      end
      jsd_pkg::ST_SCAN: begin
        if (sched_full) begin
          state_d = jsd_pkg::ST_EMIT;
        end else if (scan_end) begin
          state_d = best_v_q ? jsd_pkg::ST_SEARCH : jsd_pkg::ST_EMIT;
        end
      end
      jsd_pkg::ST_SEARCH: begin
        if (search_end) state_d = jsd_pkg::ST_SCAN;
      end
      jsd_pkg::ST_EMIT: begin
        if (emit_end) state_d = jsd_pkg::ST_FINISH;
      end
      jsd_pkg::ST_FINISH: state_d = jsd_pkg::ST_LOAD;
      default:            state_d = jsd_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= jsd_pkg::ST_LOAD;
    else         state_q <= state_d;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (pop && (count_q < jsd_pkg::JobCntW'(jsd_pkg::MaxJobs))) begin
      store_mem[count_q[jsd_pkg::JobIdxW-1:0]] <= '{head_i.id, head_i.deadline,
                                                    head_i.profit};
    end
    if (scan_issue) begin
      store_rd_q <= store_mem[addr_q[jsd_pkg::JobIdxW-1:0]];
    end
    if (slot_free) begin
      slot_mem[kk] <= '{best_q.id, best_q.profit};
    end
    if (emit_issue) begin
      slot_rd_q <= slot_mem[e_q[jsd_pkg::SlotIdxW-1:0]];
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    pidx_q <= addr_q[jsd_pkg::JobIdxW-1:0];
    if (pv_q && !taken_q[pidx_q] && (!best_v_q || (store_rd_q.profit > best_q.profit))) begin
      best_q     <= store_rd_q;
      best_idx_q <= pidx_q;
    end
    eidx_q  <= e_q[jsd_pkg::SlotIdxW-1:0];
    efill_q <= used_q[e_q[jsd_pkg::SlotIdxW-1:0]];
    elast_q <= ((e_q + 1'b1) == gd_q);
  end

  // running profit of the slot on the output
  assign acc_sum = acc_q + (efill_q ? jsd_pkg::SumW'(slot_rd_q.profit) : '0);

  // set bookkeeping and sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      gd_q     <= '0;
      filled_q <= '0;
      used_q   <= '0;
      taken_q  <= '0;
      addr_q   <= '0;
      pv_q     <= 1'b0;
      best_v_q <= 1'b0;
      k_q      <= '0;
      e_q      <= '0;
      ev_q     <= 1'b0;
      acc_q    <= '0;
    end else begin
      // load
      if (pop && (count_q < jsd_pkg::JobCntW'(jsd_pkg::MaxJobs))) begin
        count_q <= count_q + 1'b1;
        if (head_i.deadline > gd_q) gd_q <= head_i.deadline;
      end
      // scan for the best remaining job
      pv_q <= scan_issue;
      if (state_q != jsd_pkg::ST_SCAN) begin
        addr_q   <= '0;
        best_v_q <= 1'b0;
      end else begin
        if (scan_issue) addr_q <= addr_q + 1'b1;
        if (pv_q && !taken_q[pidx_q]) best_v_q <= 1'b1;
      end
      if (scan_end && best_v_q) begin
        taken_q[best_idx_q] <= 1'b1;
        k_q <= best_q.deadline;
      end
      // walk down to the latest free slot
      if (slot_free) begin
        used_q[kk] <= 1'b1;
        filled_q   <= filled_q + 1'b1;
      end else if ((state_q == jsd_pkg::ST_SEARCH) && (k_q != '0)) begin
        k_q <= k_dec;
      end
      // read-out
      ev_q <= emit_issue;
      if (state_q != jsd_pkg::ST_EMIT) begin
        e_q   <= '0;
        acc_q <= '0;
      end else begin
        if (emit_issue) e_q <= e_q + 1'b1;
        if (ev_q) acc_q <= acc_sum;
      end
      // back to empty
      if (set_done_o) begin
        count_q  <= '0;
        gd_q     <= '0;
        filled_q <= '0;
        used_q   <= '0;
        taken_q  <= '0;
      end
    end
  end

  assign slot_valid_o     = ev_q;
  assign slot_index_o     = eidx_q;
  assign slot_filled_o    = efill_q;
  assign slot_job_id_o    = efill_q ? slot_rd_q.id : '0;
  assign running_profit_o = acc_sum;
  assign last_slot_o      = elast_q;

  // checks
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= gd_q) else $error("more slots filled than exist");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= jsd_pkg::JobCntW'(jsd_pkg::MaxJobs)) else $error("job count overflow");
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_valid_o |-> $past(state_q) == jsd_pkg::ST_EMIT)
    else $error("result outside read-out");
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_done_o |=> (filled_q == '0) && (used_q == '0) && (count_q == '0))
    else $error("set not cleared");

endmodule

@@ rtl/job_sequencing_with_deadlines.sv @@
// ---------------------------------------------------------------------------
// job_sequencing_with_deadlines: greedy job sequencer
// Loads a job set, places jobs by descending profit into the latest free
// slot before each deadline, and reports every slot in time order.
// ---------------------------------------------------------------------------
// channel   direction  handshake              payload
// job       in         start && !busy         job_id_i job_deadline_i job_profit_i last_job_i
// slot      out        slot_valid_o (1 cycle) slot_index_o slot_job_id_o slot_filled_o
//                                             running_profit_o last_slot_o
//
// Jobs are taken one per cycle, while busy is low, through a 4-entry queue into
// the job store. After the last job, each job in profit order costs one store
// scan plus a walk down the slot table from its deadline to the latest free slot,
// until the slots are full or a last scan finds no job left. Read-out is one
// slot per cycle over every slot up to the greatest deadline, in time order.
// busy is high while the queue is full and from the last job through the
// cycle after the final slot. Reset is asynchronous, active low; no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module job_sequencing_with_deadlines (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [jsd_pkg::IdW-1:0]        job_id_i,
  input  logic [jsd_pkg::DlW-1:0]        job_deadline_i,
  input  logic [jsd_pkg::ProfitW-1:0]    job_profit_i,
  input  logic                           last_job_i,
  output logic                           slot_valid_o,
  output logic [jsd_pkg::SlotIdxW-1:0]   slot_index_o,
  output logic [jsd_pkg::IdW-1:0]        slot_job_id_o,
  output logic                           slot_filled_o,
  output logic [jsd_pkg::SumW-1:0]       running_profit_o,
  output logic                           last_slot_o
);

  jsd_pkg::job_t      push_data, head;
  jsd_pkg::q_status_t q_status;
  logic               push, pop, set_done;

  jsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .job_id_i       (job_id_i),
    .job_deadline_i (job_deadline_i),
    .job_profit_i   (job_profit_i),
    .last_job_i     (last_job_i),
    .q_status_i     (q_status),
    .set_done_i     (set_done),
    .busy_o         (busy),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  jsd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  jsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .q_empty_i        (q_status.empty),
    .pop_o            (pop),
    .set_done_o       (set_done),
    .slot_valid_o     (slot_valid_o),
    .slot_index_o     (slot_index_o),
    .slot_job_id_o    (slot_job_id_o),
    .slot_filled_o    (slot_filled_o),
    .running_profit_o (running_profit_o),
    .last_slot_o      (last_slot_o)
  );

endmodule
